[hw/rtl/summed_area_table_2d_unit_macros.svh]
// Assertion macros for the summed-area table unit.
// Depends on clk and arst_n being in scope where a macro is used.
`ifndef SUMMED_AREA_TABLE_2D_UNIT_MACROS_SVH
`define SUMMED_AREA_TABLE_2D_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SAT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SAT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/sat_pkg.sv]
// Shared types and constants of the summed-area table unit.
// No dependencies.
package sat_pkg;

	localparam int SUM_W           = 44;
	localparam int SIZE_W          = 7;
	localparam int CFG_INDEX_W     = 2;
	localparam int DEF_MAX_ROWS    = 64;
	localparam int DEF_MAX_COLUMNS = 64;
	localparam int DEF_SAMPLE_BITS = 32;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT    = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT = CFG_INDEX_W'(1);

	// Function codes of an input beat.
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef logic signed [SUM_W-1:0] sat_sum_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_RANGE     = 2'd1,
		STATUS_NOT_READY = 2'd2
	} sat_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD_WR,
		ST_QUERY_RD,
		ST_QUERY_OUT
	} sat_state_t;

endpackage

[hw/rtl/sat_if.sv]
// Valid/ready channel interfaces of the summed-area table unit.
// Depends on sat_pkg.
interface sat_in_if #(
	parameter int SAMPLE_BITS = sat_pkg::DEF_SAMPLE_BITS
) ();
	import sat_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     func;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic [SIZE_W-1:0]        first_row;
	logic [SIZE_W-1:0]        first_column;
	logic [SIZE_W-1:0]        stop_row;
	logic [SIZE_W-1:0]        stop_column;

	modport source (
		output valid, func, sample, first_row, first_column, stop_row, stop_column,
		input  ready
	);
	modport sink (
		input  valid, func, sample, first_row, first_column, stop_row, stop_column,
		output ready
	);
endinterface

interface sat_out_if ();
	import sat_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [SUM_W-1:0] rect_sum;
	logic [1:0]              status;

	modport source (output valid, rect_sum, status, input ready);
	modport sink   (input valid, rect_sum, status, output ready);
endinterface

[hw/rtl/summed_area_table_2d_unit.sv]
// Top level of the two-dimensional summed-area table unit.
// Depends on sat_pkg, sat_if, sat_prefix_ram and the assertion macro header.
//
//  channel   | direction | beat contents
//  ----------+-----------+-------------------------------------------------
//  items     | in        | func, sample, first_row, first_column, stop_row,
//            |           | stop_column
//  results   | out       | rect_sum, status (one beat per query)
//  cfg_*     | in        | register index and data, write enable
//
// A load first reads the entry above, then writes the new entry in ST_LOAD_WR.
// A valid query is paced by the single read port of the prefix store, which
// delivers one of the four corner entries per cycle; a rejected query goes
// straight to ST_QUERY_OUT. The store has no reset and needs no clearing pass.
// A finished query waits in its last state while the result register is full.
module summed_area_table_2d_unit #(
	parameter int MAX_ROWS    = sat_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLUMNS = sat_pkg::DEF_MAX_COLUMNS,
	parameter int SAMPLE_BITS = sat_pkg::DEF_SAMPLE_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [sat_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [sat_pkg::SIZE_W-1:0]        cfg_data,
	sat_in_if.sink                            items,
	sat_out_if.source                         results
);
	import sat_pkg::*;

	`include "summed_area_table_2d_unit_macros.svh"

	localparam int DEPTH   = MAX_ROWS * MAX_COLUMNS;
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SIZE_MAX = (1 << SIZE_W) - 1;
	localparam logic [SIZE_W-1:0] ROWS_CAP =
		SIZE_W'((MAX_ROWS > SIZE_MAX) ? SIZE_MAX : MAX_ROWS);
	localparam logic [SIZE_W-1:0] COLS_CAP =
		SIZE_W'((MAX_COLUMNS > SIZE_MAX) ? SIZE_MAX : MAX_COLUMNS);

	// Flat store address of a zero-based row and column.
	function automatic logic [AW-1:0] entry_addr(input logic [SIZE_W-1:0] r,
		input logic [SIZE_W-1:0] c);
		entry_addr = AW'(int'(r) * MAX_COLUMNS + int'(c));
	endfunction

	sat_state_t        state_q, state_next;
	logic [SIZE_W-1:0] row_count_q, column_count_q;
	logic [SIZE_W-1:0] load_row_q, load_column_q;
	logic              table_ready_q;
	sat_sum_t          rs_q;
	logic [1:0]        step_q;
	logic [SIZE_W-1:0] qr0_q, qc0_q, qr1_q, qc1_q;
	sat_status_t       status_q;
	sat_sum_t          acc_q;
	logic              rd_valid_s1, rd_zero_s1, rd_sub_s1;
	logic              out_valid_q;
	sat_sum_t          out_sum_q;
	sat_status_t       out_status_q;

	logic [SIZE_W-1:0] rows_eff, cols_eff;
	logic              accept, accept_load, accept_query;
	logic [SIZE_W-1:0] eff_row, eff_col;
	sat_sum_t          rs_new;
	logic              range_bad;
	sat_status_t       status_in;
	logic [1:0]        step_sel;
	logic [SIZE_W-1:0] sel_r0, sel_c0, sel_r1, sel_c1, sel_row, sel_col;
	logic              sel_zero, sel_sub, issue_query;
	logic [AW-1:0]     load_raddr, query_raddr;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	sat_sum_t          ram_wdata, ram_rdata;
	sat_sum_t          term_s1, acc_next;
	logic              out_free, out_load, items_ready;
	logic              col_last, row_last;

	// Effective grid size: zero reads as one, large values clamp to the maximum.
	assign rows_eff = (row_count_q == '0) ? SIZE_W'(1) :
		(row_count_q > ROWS_CAP) ? ROWS_CAP : row_count_q;
	assign cols_eff = (column_count_q == '0) ? SIZE_W'(1) :
		(column_count_q > COLS_CAP) ? COLS_CAP : column_count_q;

	assign accept       = items.valid && items_ready;
	assign accept_load  = accept && (items.func == FUNC_LOAD);
	assign accept_query = accept && (items.func == FUNC_QUERY);

	// Load position, restarting when a finished table is loaded again.
	assign eff_row = table_ready_q ? '0 : load_row_q;
	assign eff_col = table_ready_q ? '0 : load_column_q;
	assign rs_new  = ((eff_col == '0) ? sat_sum_t'(0) : rs_q) +
		SUM_W'($signed(items.sample[SAMPLE_BITS-1:0]));
	assign load_raddr = entry_addr(eff_row - SIZE_W'(1), eff_col);

	// Query status: the range check comes before the ready check.
	assign range_bad = (items.first_row > rows_eff) || (items.stop_row > rows_eff) ||
		(items.first_column > cols_eff) || (items.stop_column > cols_eff);
	assign status_in = range_bad ? STATUS_RANGE :
		(!table_ready_q ? STATUS_NOT_READY : STATUS_OK);

	// Corner selection: the accept cycle reads corner zero from the input beat.
	assign step_sel = (state_q == ST_IDLE) ? 2'd0 : step_q;
	assign sel_r0   = (state_q == ST_IDLE) ? items.first_row    : qr0_q;
	assign sel_c0   = (state_q == ST_IDLE) ? items.first_column : qc0_q;
	assign sel_r1   = (state_q == ST_IDLE) ? items.stop_row     : qr1_q;
	assign sel_c1   = (state_q == ST_IDLE) ? items.stop_column  : qc1_q;
	assign sel_row  = step_sel[1] ? sel_r0 : sel_r1;
	assign sel_col  = step_sel[0] ? sel_c0 : sel_c1;
	assign sel_zero = (sel_row == '0) || (sel_col == '0);
	assign sel_sub  = step_sel[1] ^ step_sel[0];
	assign query_raddr = entry_addr(sel_row - SIZE_W'(1), sel_col - SIZE_W'(1));

	// Last-position flags of the raster walk.
	assign col_last = (load_column_q == cols_eff - SIZE_W'(1));
	assign row_last = (load_row_q == rows_eff - SIZE_W'(1));

	// Accumulation of the corner whose read data has just arrived.
	assign term_s1  = (rd_valid_s1 && !rd_zero_s1) ?
		(rd_sub_s1 ? -ram_rdata : ram_rdata) : sat_sum_t'(0);
	assign acc_next = acc_q + term_s1;
	assign out_free = !out_valid_q || results.ready;

	// Next state.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept_load) begin
					state_next = ST_LOAD_WR;
				end else if (accept_query) begin
					state_next = (status_in == STATUS_OK) ? ST_QUERY_RD : ST_QUERY_OUT;
				end
			end
			ST_LOAD_WR: begin
				state_next = ST_IDLE;
			end
			ST_QUERY_RD: begin
				if (step_q == 2'd3) begin
					state_next = ST_QUERY_OUT;
				end
			end
			ST_QUERY_OUT: begin
				if (out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// State outputs: handshake, store access and result load.
	always_comb begin
		items_ready = 1'b0;
		ram_we      = 1'b0;
		issue_query = 1'b0;
		out_load    = 1'b0;
		ram_raddr   = query_raddr;
		unique case (state_q)
			ST_IDLE: begin
				items_ready = 1'b1;
				if (items.func == FUNC_LOAD) begin
					ram_raddr = load_raddr;
				end
				issue_query = accept_query && (status_in == STATUS_OK);
			end
			ST_LOAD_WR: begin
				ram_we = 1'b1;
			end
			ST_QUERY_RD: begin
				issue_query = 1'b1;
			end
			ST_QUERY_OUT: begin
				out_load = out_free;
			end
			default: begin
				items_ready = 1'b0;
			end
		endcase
	end

	// New entry: row running sum plus the entry above it.
	assign ram_waddr = entry_addr(load_row_q, load_column_q);
	assign ram_wdata = rs_q + ((load_row_q == '0) ? sat_sum_t'(0) : ram_rdata);

	sat_prefix_ram #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (SUM_W)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Control state and load position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			row_count_q    <= SIZE_RESET;
			column_count_q <= SIZE_RESET;
			load_row_q     <= '0;
			load_column_q  <= '0;
			table_ready_q  <= 1'b0;
			rs_q           <= '0;
			step_q         <= '0;
			rd_valid_s1    <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q     <= state_next;
			rd_valid_s1 <= issue_query;

			if (accept_load) begin
				load_row_q    <= eff_row;
				load_column_q <= eff_col;
				table_ready_q <= 1'b0;
				rs_q          <= rs_new;
			end

			// Advance the raster position once the entry is written.
			if (ram_we) begin
				if (col_last) begin
					load_column_q <= '0;
					if (row_last) begin
						load_row_q    <= '0;
						table_ready_q <= 1'b1;
					end else begin
						load_row_q <= load_row_q + SIZE_W'(1);
					end
				end else begin
					load_column_q <= load_column_q + SIZE_W'(1);
				end
			end

			if (accept_query) begin
				step_q <= 2'd1;
			end else if (state_q == ST_QUERY_RD) begin
				step_q <= step_q + 2'd1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end

			// A write to the row or column count register restarts loading of the table.
			if (cfg_write &&
				(cfg_index == CFG_ROW_COUNT || cfg_index == CFG_COLUMN_COUNT)) begin
				if (cfg_index == CFG_ROW_COUNT) begin
					row_count_q <= cfg_data;
				end else begin
					column_count_q <= cfg_data;
				end
				load_row_q    <= '0;
				load_column_q <= '0;
				table_ready_q <= 1'b0;
				rs_q          <= '0;
			end
		end
	end

	// Query payload, read tags and result register.
	always_ff @(posedge clk) begin
		rd_zero_s1 <= sel_zero;
		rd_sub_s1  <= sel_sub;
		if (accept_query) begin
			qr0_q    <= items.first_row;
			qc0_q    <= items.first_column;
			qr1_q    <= items.stop_row;
			qc1_q    <= items.stop_column;
			status_q <= status_in;
			acc_q    <= '0;
		end else begin
			acc_q <= acc_next;
		end
		if (out_load) begin
			out_sum_q    <= (status_q == STATUS_OK) ? acc_next : sat_sum_t'(0);
			out_status_q <= status_q;
		end
	end

	assign items.ready      = items_ready;
	assign results.valid    = out_valid_q;
	assign results.rect_sum = out_sum_q;
	assign results.status   = out_status_q;

	// Checks on sequencing and result contents.
	`SAT_ASSERT_NOW(a_err_sum_zero, results.valid && results.status != STATUS_OK, results.rect_sum == '0, "rejected query carries a nonzero sum")
	`SAT_ASSERT_NEXT(a_load_writes, accept_load, state_q == ST_LOAD_WR, "load beat not followed by its store write")
	`SAT_ASSERT_NOW(a_read_in_query, rd_valid_s1, state_q == ST_QUERY_RD || state_q == ST_QUERY_OUT, "corner data arrived outside a query")
	`SAT_ASSERT_NEXT(a_cfg_restart, cfg_write && cfg_index == CFG_ROW_COUNT, !table_ready_q && load_row_q == '0, "register write did not restart loading")
endmodule

[hw/rtl/sat_prefix_ram.sv]
// Prefix-sum store: one write port and one read port with registered data.
// Depends on nothing but its parameters.
module sat_prefix_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int DW    = 44
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	// Write and read in the same clock; read data is registered and appears in the next cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule
